// File: rtl/sharpen_3x3_rgb_filter_assert.svh
// assertion macros used by the checker file
`ifndef SHARPEN_3X3_RGB_FILTER_ASSERT_SVH
`define SHARPEN_3X3_RGB_FILTER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define SH3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define SH3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sh3_pkg.sv
package sh3_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;

  localparam int unsigned WIDTH_RST  = 640;
  localparam int unsigned HEIGHT_RST = 480;

  localparam int unsigned PIX_CH     = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 12;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // kernel and clip constants
  localparam int unsigned CENTRE_GAIN = 9;
  localparam logic [7:0]  CLIP_MAX    = 8'd255;

  // channel 0 blue, 1 green, 2 red
  typedef logic [PIX_CH-1:0][7:0] pix_t;
  // row 0 top, 1 middle, 2 bottom
  typedef pix_t [2:0] col_t;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
    int unsigned r;
    r = v;
    if (v < 1) r = 1;
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

// File: rtl/sh3_if.sv
interface sh3_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;

  modport source (output valid, kind, blue_in, green_in, red_in, input ready);
  modport sink   (input valid, kind, blue_in, green_in, red_in, output ready);
endinterface

interface sh3_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic       frame_end;

  modport source (output valid, blue_out, green_out, red_out, frame_end, input ready);
  modport sink   (input valid, blue_out, green_out, red_out, frame_end, output ready);
endinterface

// File: rtl/sh3_line_buf.sv
module sh3_line_buf #(
  parameter int unsigned MAX_WIDTH = sh3_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic                         bank_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr_i,
  input  sh3_pkg::pix_t                wdata_i,
  output sh3_pkg::pix_t                rd0_o,
  output sh3_pkg::pix_t                rd1_o
);
  import sh3_pkg::*;

  // two line stores picked by row parity, read-first
  pix_t mem0 [MAX_WIDTH];
  pix_t mem1 [MAX_WIDTH];
  pix_t rd0_q;
  pix_t rd1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd0_q <= mem0[addr_i];
      if (!bank_i) mem0[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd1_q <= mem1[addr_i];
      if (bank_i) mem1[addr_i] <= wdata_i;
    end
  end

  assign rd0_o = rd0_q;
  assign rd1_o = rd1_q;

endmodule

// File: rtl/sh3_lane.sv
module sh3_lane (
  input  logic [7:0]      centre_i,
  input  logic [7:0][7:0] nbr_i,
  output logic [7:0]      res_o
);
  import sh3_pkg::*;

  logic [10:0]        nsum;
  logic [11:0]        cen_g;
  logic signed [12:0] diff;

  always_comb begin
    nsum = '0;
    for (int k = 0; k < 8; k++) begin
      nsum = nsum + 11'(nbr_i[k]);
    end
  end

  assign cen_g = 12'(CENTRE_GAIN) * 12'(centre_i);
  assign diff  = $signed({1'b0, cen_g}) - $signed({2'b00, nsum});

  // clip to 0..255
  always_comb begin
    if (diff[12]) res_o = '0;
    else if (diff > 13'sd255) res_o = CLIP_MAX;
    else res_o = diff[7:0];
  end

endmodule

// File: rtl/sharpen_3x3_rgb_filter.sv
// channel   dir  handshake     payload
// in_if     in   valid/ready   kind, blue_in, green_in, red_in
// out_if    out  valid/ready   blue_out, green_out, red_out, frame_end
// cfg       in   cfg_we_i      cfg_idx_i, cfg_data_i (write only)
//
// one item per cycle while out_if does not stall; the result of an item passes the
// accept stage, the window into the view register, then the lanes into the output register
// each item reads both line-store banks once and writes one, at its column
// reset clears counters, window and valid flags; line stores are not cleared
// a stall on out_if backs up through the pipe; empty stages still take items
// a config write restarts the frame counters
module sharpen_3x3_rgb_filter #(
  parameter int unsigned MAX_WIDTH  = sh3_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sh3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  sh3_in_if.sink                           in_if,
  sh3_out_if.source                        out_if,
  input  logic                             cfg_we_i,
  input  logic [sh3_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sh3_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import sh3_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);       // column index
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);  // row count runs to height+1

  // control carried from the accept stage into the window stage
  typedef struct packed {
    logic top_en;   // upper line store entry belongs to this frame
    logic mid_en;   // middle line store entry belongs to this frame
    logic bank;     // row parity of the item
    logic col0;     // first column: right neighbours are outside
    logic lzero;    // output column is the leftmost
    logic emit;     // item gives a result
    logic last;     // result closes the frame
  } b_ctl_t;

  // frame geometry, clamped at write time
  logic [CW-1:0] col_last_q;
  logic [RW-1:0] height_q;

  // raster position of the next item
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;

  // handshake
  logic acc, in_ready, b_leave, v_take, out_free;

  // accept stage -> window stage
  logic   b_v_q;
  b_ctl_t b_ctl_q;
  pix_t   b_pix_q;
  b_ctl_t a_ctl;
  pix_t   a_pix;

  // line store read data
  pix_t rd0, rd1;

  // window: last two columns seen
  col_t win1_q, win2_q;
  col_t new_col;

  // view register feeding the lanes
  logic v_v_q;
  logic v_last_q;
  col_t v_left_q, v_cen_q, v_right_q;

  // output register
  logic o_v_q;
  logic o_last_q;
  pix_t o_pix_q;
  pix_t lane_res;

  assign out_free = !o_v_q || out_if.ready;
  assign v_take   = !v_v_q || out_free;
  assign b_leave  = b_v_q && (v_take || !b_ctl_q.emit);
  assign in_ready = !b_v_q || b_leave;
  assign acc      = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  // per-item decode from the raster position
  always_comb begin
    a_ctl.top_en = (row_q >= RW'(2));
    a_ctl.mid_en = (row_q >= RW'(1)) && (row_q <= height_q);
    a_ctl.bank   = row_q[0];
    a_ctl.col0   = (col_q == '0);
    a_ctl.lzero  = (col_q == CW'(1)) || ((col_q == '0) && (col_last_q == '0));
    a_ctl.emit   = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
    a_ctl.last   = (col_q == '0) && (row_q > height_q);
    // drain items and items past the frame write black
    if ((in_if.kind == KIND_PIXEL) && (row_q < height_q)) begin
      a_pix = {in_if.red_in, in_if.green_in, in_if.blue_in};
    end else begin
      a_pix = '0;
    end
  end

  // config and raster counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q <= CW'(clamp_size(WIDTH_RST, MAX_WIDTH) - 1);
      height_q   <= RW'(clamp_size(HEIGHT_RST, MAX_HEIGHT));
      col_q      <= '0;
      row_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH: begin
          col_last_q <= CW'(clamp_size(32'(cfg_data_i), MAX_WIDTH) - 1);
          col_q      <= '0;
          row_q      <= '0;
        end
        CFG_HEIGHT: begin
          height_q <= RW'(clamp_size(32'(cfg_data_i), MAX_HEIGHT));
          col_q    <= '0;
          row_q    <= '0;
        end
        default: begin
        end
      endcase
    end else if (acc) begin
      if (a_ctl.last) begin
        col_q <= '0;
        row_q <= '0;
      end else if (col_q == col_last_q) begin
        col_q <= '0;
        row_q <= row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  sh3_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .en_i    (acc),
    .bank_i  (a_ctl.bank),
    .addr_i  (col_q),
    .wdata_i (a_pix),
    .rd0_o   (rd0),
    .rd1_o   (rd1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (acc) begin
      b_v_q <= 1'b1;
    end else if (b_leave) begin
      b_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      b_ctl_q <= a_ctl;
      b_pix_q <= a_pix;
    end
  end

  // new column: same bank as this row holds two rows up, the other bank one up
  always_comb begin
    new_col[2] = b_pix_q;
    if (b_ctl_q.top_en) new_col[0] = b_ctl_q.bank ? rd1 : rd0;
    else new_col[0] = '0;
    if (b_ctl_q.mid_en) new_col[1] = b_ctl_q.bank ? rd0 : rd1;
    else new_col[1] = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win1_q <= '0;
      win2_q <= '0;
    end else if (b_leave) begin
      win1_q <= win2_q;
      win2_q <= new_col;
    end
  end

  // view around the output pixel, image borders padded with zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_v_q <= 1'b0;
    end else if (b_leave && b_ctl_q.emit) begin
      v_v_q <= 1'b1;
    end else if (v_v_q && out_free) begin
      v_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_leave && b_ctl_q.emit) begin
      v_left_q  <= b_ctl_q.lzero ? '0 : win1_q;
      v_cen_q   <= win2_q;
      v_right_q <= b_ctl_q.col0 ? '0 : new_col;
      v_last_q  <= b_ctl_q.last;
    end
  end

  // one lane per colour channel
  for (genvar ch = 0; ch < PIX_CH; ch++) begin : g_lane
    logic [7:0][7:0] nbr;

    always_comb begin
      for (int r = 0; r < 3; r++) begin
        nbr[r]     = v_left_q[r][ch];
        nbr[r + 3] = v_right_q[r][ch];
      end
      nbr[6] = v_cen_q[0][ch];
      nbr[7] = v_cen_q[2][ch];
    end

    sh3_lane u_lane (
      .centre_i (v_cen_q[1][ch]),
      .nbr_i    (nbr),
      .res_o    (lane_res[ch])
    );
  end

  // merge lane results into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (v_v_q && out_free) begin
      o_v_q <= 1'b1;
    end else if (out_if.ready) begin
      o_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_v_q && out_free) begin
      o_pix_q  <= lane_res;
      o_last_q <= v_last_q;
    end
  end

  assign out_if.valid     = o_v_q;
  assign out_if.blue_out  = o_pix_q[0];
  assign out_if.green_out = o_pix_q[1];
  assign out_if.red_out   = o_pix_q[2];
  assign out_if.frame_end = o_last_q;

endmodule

// File: rtl/sh3_checker.sv
`include "sharpen_3x3_rgb_filter_assert.svh"

module sh3_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [24:0] out_data_i
);

  `SH3_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `SH3_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_data_i), "result changed while stalled")
  `SH3_ASSERT_NOW(a_ready_when_empty, !out_valid_i, in_ready_i, "input blocked with empty output")
  `SH3_ASSERT_NOW(a_ready_when_drained, out_ready_i, in_ready_i, "input blocked while output drains")

endmodule

bind sharpen_3x3_rgb_filter sh3_checker u_sh3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  ({out_if.frame_end, out_if.red_out, out_if.green_out, out_if.blue_out})
);
